### hw/rtl/dual_contact_velocity_timer_macros.svh
// ----------------------------------------------------------------------------
// dual contact velocity timer assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef DUAL_CONTACT_VELOCITY_TIMER_MACROS_SVH
`define DUAL_CONTACT_VELOCITY_TIMER_MACROS_SVH

// same-cycle implication
`define DCVT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define DCVT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/dcvt_pkg.sv
// ----------------------------------------------------------------------------
// dcvt package
// transaction types, register map and shared constants
// ----------------------------------------------------------------------------
`default_nettype none

package dcvt_pkg;

  localparam int unsigned TS_W       = 32;
  localparam int unsigned DEBOUNCE_W = 16;
  localparam int unsigned PDATA_W    = 32;
  localparam int unsigned PADDR_W    = 3;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd10;

  // register byte addresses
  localparam logic [PADDR_W-1:0] ADDR_DEBOUNCE_MS = 3'd0;

  typedef struct packed {
    logic            first_pressed;
    logic            second_pressed;
    logic [TS_W-1:0] now_ms;
    logic [TS_W-1:0] now_us;
  } sample_t;

  typedef struct packed {
    logic signed [TS_W-1:0] time_difference;
    logic                   measured;
  } result_t;

  typedef struct packed {
    logic            captured;
    logic [TS_W-1:0] press_us;
  } contact_status_t;

endpackage

`default_nettype wire

### hw/rtl/dcvt_contact.sv
// ----------------------------------------------------------------------------
// dcvt contact tracker
// edge detect, debounce timing and press time capture for one contact
// ----------------------------------------------------------------------------
`default_nettype none

module dcvt_contact
  import dcvt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  advance,
  input  wire logic                  level,
  input  wire logic                  rearm,
  input  wire logic [TS_W-1:0]       now_ms,
  input  wire logic [TS_W-1:0]       now_us,
  input  wire logic [DEBOUNCE_W-1:0] debounce_ms,
  output contact_status_t            status,
  output logic                       captured
);

  logic            level_prev;
  logic [TS_W-1:0] debounce_start;
  logic [TS_W-1:0] debounce_start_next;
  logic [TS_W-1:0] press_us;
  logic [TS_W-1:0] held_ms;
  logic            take;

  assign held_ms = now_ms - debounce_start;
  assign take    = level && level_prev && !captured &&
                   (held_ms > {{(TS_W-DEBOUNCE_W){1'b0}}, debounce_ms});

  always_comb begin
    debounce_start_next = debounce_start;
    if (level && !level_prev) begin
      debounce_start_next = now_ms;
    end
    status.captured = captured || take;
    status.press_us = take ? now_us : press_us;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_prev     <= 1'b0;
      captured       <= 1'b0;
      debounce_start <= '0;
      press_us       <= '0;
    end else if (advance) begin
      level_prev     <= level;
      captured       <= status.captured && !rearm;
      debounce_start <= debounce_start_next;
      press_us       <= status.press_us;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/dual_contact_velocity_timer.sv
// ----------------------------------------------------------------------------
// dual contact velocity timer
// key velocity measurement from two debounced contacts
// ----------------------------------------------------------------------------
// One sample transaction goes in and exactly one result transaction comes out
// for it, one per clock when neither side stalls. A sample lands in an input
// register; when the stage advances, both contact trackers and the measurement
// check run in one pass and load the result register, so the sustained rate is
// one sample per cycle while results drain. Each contact starts a debounce timer
// on a new press and captures now_us once it has been held longer than
// debounce_ms milliseconds. When both are captured the result carries
// second minus first (wrapping, signed) with measured set, once; otherwise the
// difference is zero. Releasing both contacts re-arms the measurement.
// debounce_ms sits at byte address 0 of the register port, reset value 10,
// and should only be written while no transaction is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dual_contact_velocity_timer_macros.svh"

module dual_contact_velocity_timer
  import dcvt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // sample channel
  input  wire logic               sample_valid,
  output logic                    sample_ready,
  input  wire sample_t            sample,
  // result channel
  output logic                    result_valid,
  input  wire logic               result_ready,
  output result_t                 result,
  // register port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready
);

  // register file
  logic [DEBOUNCE_W-1:0] debounce_ms;

  // input stage
  sample_t stage;
  logic    stage_valid;
  logic    advance;

  // per-contact results and state
  contact_status_t first_status;
  contact_status_t second_status;
  logic            first_captured;
  logic            second_captured;
  logic            measurement_done;
  logic            rearm;
  result_t         result_next;

  // apb register access, pready always high, no wait states
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= DEBOUNCE_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_DEBOUNCE_MS) begin
      debounce_ms <= pwdata[DEBOUNCE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_DEBOUNCE_MS) begin
      prdata = {{(PDATA_W-DEBOUNCE_W){1'b0}}, debounce_ms};
    end
  end

  // the input stage moves on whenever the result register is free or draining
  assign advance      = stage_valid && (!result_valid || result_ready);
  assign sample_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (sample_ready) begin
      stage_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_ready && sample_valid) begin
      stage <= sample;
    end
  end

  // both contacts released: clear captures and the done flag
  assign rearm = !stage.first_pressed && !stage.second_pressed;

  dcvt_contact u_first (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .level       (stage.first_pressed),
    .rearm       (rearm),
    .now_ms      (stage.now_ms),
    .now_us      (stage.now_us),
    .debounce_ms (debounce_ms),
    .status      (first_status),
    .captured    (first_captured)
  );

  dcvt_contact u_second (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .level       (stage.second_pressed),
    .rearm       (rearm),
    .now_ms      (stage.now_ms),
    .now_us      (stage.now_us),
    .debounce_ms (debounce_ms),
    .status      (second_status),
    .captured    (second_captured)
  );

  // report once per press pair, after both press times are in
  always_comb begin
    result_next.measured        = first_status.captured && second_status.captured &&
                                  !measurement_done;
    result_next.time_difference = '0;
    if (result_next.measured) begin
      result_next.time_difference = signed'(second_status.press_us - first_status.press_us);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      measurement_done <= 1'b0;
    end else if (advance) begin
      measurement_done <= (measurement_done || result_next.measured) && !rearm;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  // a reported pair stays marked done until re-armed
  `DCVT_ASSERT_NEXT(a_done_after_measure, advance && result_next.measured, measurement_done)
  // done is only held while both press times are captured
  `DCVT_ASSERT_NOW(a_done_needs_captures, measurement_done, first_captured && second_captured)
  // an empty input stage never stalls the sample side
  `DCVT_ASSERT_NOW(a_ready_when_empty, !stage_valid, sample_ready)
  // no difference is reported without a measurement
  `DCVT_ASSERT_NOW(a_zero_without_measure, result_valid && !result.measured,
                   result.time_difference == 0)

endmodule

`default_nettype wire

### test/dual_contact_velocity_timer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual contact velocity timer testbench
// drives sample transactions through a bursty sender, takes result
// transactions on a stalling receiver and checks each one against a
// cycle-free predictor of the two contact trackers, over several debounce
// settings written on the register port between phases
// ----------------------------------------------------------------------------

module dual_contact_velocity_timer_tb;
  import dcvt_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS    = 126;
  localparam int unsigned DRAIN_CYCLES   = 4;

  // which contact goes down first in a generated keystroke
  typedef enum {LEAD_FIRST, LEAD_SECOND, LEAD_BOTH} lead_t;
  // receiver behavior, re-picked at random after each run
  typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE} ready_mode_t;

  // predictor copy of one contact tracker
  typedef struct packed {
    logic            level_prev;
    logic            captured;
    logic [TS_W-1:0] start_ms;
    logic [TS_W-1:0] press_us;
  } contact_track_t;

  logic               clk;
  logic               rst;
  logic               sample_valid;
  logic               sample_ready;
  sample_t            sample;
  logic               result_valid;
  logic               result_ready;
  result_t            result;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  dual_contact_velocity_timer dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // samples waiting for the driver, results waiting for the dut
  sample_t pending_samples[$];
  result_t expected_velocity[$];

  // predictor state
  contact_track_t  first_track;
  contact_track_t  second_track;
  logic            velocity_reported;
  logic [15:0]     debounce_cfg;

  // stimulus timestamps, advanced item by item
  logic [TS_W-1:0] cur_ms;
  logic [TS_W-1:0] cur_us;
  int unsigned     queued_items;

  int unsigned     fail_count;
  int unsigned     idle_cycles;
  bit              sample_taken;
  bit              result_taken;

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  // one contact: new press starts the debounce timer, a held press longer
  // than the debounce time latches the microsecond stamp once
  function automatic contact_track_t track_contact_level(contact_track_t c, logic level,
                                                         logic [TS_W-1:0] ms,
                                                         logic [TS_W-1:0] us);
    contact_track_t  n;
    logic [TS_W-1:0] held;
    n    = c;
    held = ms - c.start_ms;   // wraps harmlessly modulo 2^32
    if (level && c.level_prev) begin
      if (!c.captured && held > {16'd0, debounce_cfg}) begin
        n.press_us = us;
        n.captured = 1'b1;
      end
    end else if (level) begin
      n.start_ms = ms;
    end
    n.level_prev = level;
    return n;
  endfunction

  function automatic result_t compute_key_velocity(sample_t s);
    result_t r;
    r.time_difference = '0;
    r.measured        = 1'b0;
    first_track  = track_contact_level(first_track, s.first_pressed, s.now_ms, s.now_us);
    second_track = track_contact_level(second_track, s.second_pressed, s.now_ms, s.now_us);
    if (first_track.captured && second_track.captured && !velocity_reported) begin
      r.time_difference = second_track.press_us - first_track.press_us;
      r.measured        = 1'b1;
      velocity_reported = 1'b1;
    end
    // both contacts up re-arms, checked after the measurement
    if (!s.first_pressed && !s.second_pressed) begin
      first_track.captured  = 1'b0;
      second_track.captured = 1'b0;
      velocity_reported     = 1'b0;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // monitor: check results, predict accepted samples, watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      sample_taken = 1'b0;
      result_taken = 1'b0;
      idle_cycles  = 0;
    end else begin
      sample_taken = sample_valid && sample_ready;
      result_taken = result_valid && result_ready;
      // compare before predicting, the dut cannot return a sample in the
      // same cycle it takes it
      if (result_taken) begin
        if (expected_velocity.size() == 0) begin
          $error("unexpected result transaction: time_difference %0d measured %0b",
                 result.time_difference, result.measured);
          fail_count++;
        end else begin
          want = expected_velocity.pop_front();
          if (result.time_difference !== want.time_difference) begin
            $error("time_difference mismatch: expected %0d actual %0d",
                   want.time_difference, result.time_difference);
            fail_count++;
          end
          if (result.measured !== want.measured) begin
            $error("measured mismatch: expected %0b actual %0b",
                   want.measured, result.measured);
            fail_count++;
          end
        end
      end
      if (sample_taken) begin
        expected_velocity.push_back(compute_key_velocity(sample));
      end
      if (sample_taken || result_taken) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // driver: bursts of sample transactions with random gaps
  // --------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(negedge clk) begin : driver
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (!sample_valid || sample_taken) begin
      // previous transaction done (or none): next one, a gap, or idle
      if (gap_left > 0) begin
        gap_left--;
        sample_valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        sample       <= pending_samples.pop_front();
        sample_valid <= 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: ready pattern switching between free flow, coin flip and
  // mostly stalled
  // --------------------------------------------------------------------------
  ready_mode_t ready_mode = READY_ALWAYS;
  int unsigned ready_run  = 0;

  always @(negedge clk) begin : receiver
    int unsigned pick;
    if (ready_run == 0) begin
      pick = $urandom_range(0, 2);
      if (pick == 0) ready_mode = READY_ALWAYS;
      else if (pick == 1) ready_mode = READY_COIN;
      else ready_mode = READY_SPARSE;
      ready_run = $urandom_range(20, 120);
    end
    ready_run--;
    case (ready_mode)
      READY_ALWAYS: result_ready <= 1'b1;
      READY_COIN:   result_ready <= ($urandom_range(0, 1) == 1);
      default:      result_ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_sample(input logic f, input logic s,
                              input logic [TS_W-1:0] ms, input logic [TS_W-1:0] us);
    sample_t item;
    item.first_pressed  = f;
    item.second_pressed = s;
    item.now_ms         = ms;
    item.now_us         = us;
    pending_samples.push_back(item);
    queued_items++;
  endtask

  // next sample on the running clock; ms steps cluster around the debounce
  // threshold so captures land on either side of it
  task automatic step_sample(input logic f, input logic s);
    int unsigned deb;
    int unsigned ms_step;
    deb = 32'(debounce_cfg);
    case ($urandom_range(0, 9))
      0:             ms_step = 0;
      1, 2, 3, 4, 5: ms_step = $urandom_range(0, deb / 2 + 2);
      6, 7, 8:       ms_step = deb + $urandom_range(0, 2);
      default:       ms_step = $urandom();
    endcase
    cur_ms = cur_ms + ms_step;
    if ($urandom_range(0, 3) == 0) cur_us = cur_us + $urandom();
    else cur_us = cur_us + $urandom_range(0, 1 << 20);
    queue_sample(f, s, cur_ms, cur_us);
  endtask

  // release, lead contact down, both held (with the odd bounce), maybe a
  // partial release before the next keystroke
  task automatic add_keystroke();
    lead_t       lead;
    int unsigned pick;
    int unsigned gap;
    int unsigned hold;
    logic        f;
    logic        s;
    pick = $urandom_range(0, 2);
    if (pick == 0) lead = LEAD_FIRST;
    else if (pick == 1) lead = LEAD_SECOND;
    else lead = LEAD_BOTH;
    gap  = $urandom_range(0, 3);
    hold = $urandom_range(2, 8);
    repeat ($urandom_range(1, 3)) step_sample(1'b0, 1'b0);
    repeat (gap) step_sample(lead != LEAD_SECOND, lead != LEAD_FIRST);
    repeat (hold) begin
      f = 1'b1;
      s = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) == 1) f = 1'b0;
        else s = 1'b0;
      end
      step_sample(f, s);
    end
    if ($urandom_range(0, 1) == 1) begin
      f = 1'($urandom_range(0, 1));
      step_sample(f, !f);
    end
  endtask

  // pass when the sender has run dry and every expected result has come,
  // then let the pipeline settle
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_samples.size() != 0 || sample_valid || expected_velocity.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    if (addr == ADDR_DEBOUNCE_MS) debounce_cfg = data[15:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // one phase: new debounce setting, then keystrokes mixed with noise
  task automatic run_phase(input logic [PDATA_W-1:0] debounce_word);
    int unsigned first_item;
    apb_write(ADDR_DEBOUNCE_MS, debounce_word);
    cur_ms     = $urandom();
    cur_us     = $urandom();
    first_item = queued_items;
    while (queued_items - first_item < PHASE_ITEMS) begin
      if ($urandom_range(0, 9) < 8) begin
        add_keystroke();
      end else begin
        // noise: arbitrary levels and timestamps
        repeat ($urandom_range(1, 4)) begin
          queue_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       $urandom(), $urandom());
        end
      end
    end
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    rst          = 1'b1;
    sample_valid = 1'b0;
    sample       = '0;
    result_ready = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    first_track       = '0;
    second_track      = '0;
    velocity_reported = 1'b0;
    debounce_cfg      = DEBOUNCE_RESET;
    queued_items      = 0;
    fail_count        = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part at the reset debounce of 10 ms
    // press held from reset counts as new, ms wraps during the hold,
    // held exactly 10 does not capture, 11 does; largest positive difference
    queue_sample(1'b1, 1'b0, 32'hFFFF_FFFA, 32'h0000_0000);
    queue_sample(1'b1, 1'b1, 32'hFFFF_FFFB, 32'h0000_0001);
    queue_sample(1'b1, 1'b1, 32'h0000_0004, 32'h1234_5678);
    queue_sample(1'b1, 1'b1, 32'h0000_0005, 32'h0000_0000);
    queue_sample(1'b1, 1'b1, 32'h0000_0006, 32'h7FFF_FFFF);
    // reported once only; one contact up does not re-arm, both up does
    queue_sample(1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_sample(1'b0, 1'b1, 32'h0000_0000, 32'h0000_0000);
    queue_sample(1'b0, 1'b0, 32'h0000_0000, 32'h0000_0000);
    // second contact leads, most negative difference
    queue_sample(1'b0, 1'b1, 32'd1000, 32'h5555_5555);
    queue_sample(1'b1, 1'b1, 32'd1001, 32'hAAAA_AAAA);
    queue_sample(1'b1, 1'b1, 32'd1011, 32'h8000_0000);
    queue_sample(1'b1, 1'b1, 32'd1012, 32'h0000_0000);
    queue_sample(1'b0, 1'b0, 32'd1013, 32'h0000_0000);
    // bounce restarts the timer; a captured contact stays captured after
    // it lifts, so the second press alone completes the measurement
    queue_sample(1'b1, 1'b0, 32'd2000, 32'h0000_0001);
    queue_sample(1'b1, 1'b0, 32'd2005, 32'h0000_0002);
    queue_sample(1'b0, 1'b0, 32'd2006, 32'h0000_0003);
    queue_sample(1'b1, 1'b0, 32'd2007, 32'h0000_0004);
    queue_sample(1'b1, 1'b0, 32'd2017, 32'h0000_0005);
    queue_sample(1'b1, 1'b0, 32'd2018, 32'h0000_1000);
    queue_sample(1'b0, 1'b1, 32'd2019, 32'h0000_0006);
    queue_sample(1'b0, 1'b1, 32'd2030, 32'h0000_0800);
    queue_sample(1'b0, 1'b0, 32'd2031, 32'h0000_0000);
    // both contacts together, same capture stamp gives zero with measured set
    queue_sample(1'b1, 1'b1, 32'd2040, 32'h0000_0007);
    queue_sample(1'b1, 1'b1, 32'd2051, 32'hDEAD_BEEF);
    queue_sample(1'b0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_drained();

    // random phases; upper write bits are junk and must be dropped
    run_phase({16'hA5C3, 16'd0});
    run_phase({16'h0000, 16'hFFFF});
    run_phase({16'h5A3C, 16'd1});
    run_phase({16'h0000, 16'($urandom_range(2, 400))});
    run_phase({16'hFFFF, 16'd10});

    repeat (8) @(posedge clk);
    if (fail_count == 0 && expected_velocity.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
